@@ src/wrfs_pkg.sv @@
// shared widths, codes and the mul-div request type of the fair-share shaper
package wrfs_pkg;

  localparam int DataW    = 48;
  localparam int ProdW    = 2 * DataW;
  localparam int LimitW   = 40;
  localparam int MaskW    = 8;
  localparam int ApbAddrW = 5;
  localparam int ApbDataW = 64;

  localparam logic [DataW-1:0] RateScale = DataW'(1000000);

  typedef enum logic [1:0] {
    MODE_UPDATE = 2'd0,
    MODE_SLIDE  = 2'd1,
    MODE_DELAY  = 2'd2,
    MODE_PAUSE  = 2'd3
  } mode_e;

  // one request to the shared multiply-then-divide unit: quot = a * b / d
  typedef struct packed {
    logic             start;
    logic [DataW-1:0] a;
    logic [DataW-1:0] b;
    logic [DataW-1:0] d;
  } md_req_t;

endpackage

@@ src/wrfs_muldiv.sv @@
// iterative unit: shift-add multiply, then restoring divide, one bit a cycle
module wrfs_muldiv (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  wrfs_pkg::md_req_t     req_i,
  output logic                  done_o,
  output logic [wrfs_pkg::ProdW-1:0] quot_o
);
  import wrfs_pkg::*;

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_MUL,
    MD_DIV
  } md_state_e;

  localparam int CntW = $clog2(ProdW);

  md_state_e        state_q;
  logic [CntW-1:0]  cnt_q;
  logic [ProdW-1:0] acc_q;
  logic [DataW-1:0] b_q;
  logic [DataW-1:0] d_q;
  logic [DataW-1:0] rem_q;
  logic             done_q;

  logic [DataW:0]   mul_sum;
  logic [DataW:0]   rem_sh;
  logic [DataW:0]   rem_sub;
  logic             rem_ge;

  always_comb begin
    mul_sum = {1'b0, acc_q[ProdW-1:DataW]} + (acc_q[0] ? {1'b0, b_q} : '0);
    rem_sh  = {rem_q, acc_q[ProdW-1]};
    rem_ge  = rem_sh >= {1'b0, d_q};
    rem_sub = rem_sh - {1'b0, d_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MD_IDLE;
      cnt_q   <= '0;
      acc_q   <= '0;
      b_q     <= '0;
      d_q     <= '0;
      rem_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        MD_IDLE: begin
          if (req_i.start) begin
            acc_q   <= {{DataW{1'b0}}, req_i.a};
            b_q     <= req_i.b;
            d_q     <= req_i.d;
            cnt_q   <= '0;
            state_q <= MD_MUL;
          end
        end
        MD_MUL: begin
          acc_q <= {mul_sum, acc_q[DataW-1:1]};
          if (cnt_q == CntW'(DataW - 1)) begin
            cnt_q   <= '0;
            rem_q   <= '0;
            state_q <= MD_DIV;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        MD_DIV: begin
          rem_q <= rem_ge ? rem_sub[DataW-1:0] : rem_sh[DataW-1:0];
          acc_q <= {acc_q[ProdW-2:0], rem_ge};
          if (cnt_q == CntW'(ProdW - 1)) begin
            done_q  <= 1'b1;
            state_q <= MD_IDLE;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        default: state_q <= MD_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign quot_o = acc_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> state_q == MD_IDLE)
    else $error("mul-div started while busy");

  a_divisor_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> req_i.d != '0)
    else $error("mul-div started with zero divisor");

  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == MD_DIV |-> rem_q < d_q)
    else $error("partial remainder not below divisor");

endmodule

@@ src/windowed_rate_fair_share_shaper_unit.sv @@
// top level of the windowed-rate fair-share shaper: meter memory, sequencer, apb registers
// a pause, or a slide without a change, passes only the read and output states; each mul-div
//   pass runs 48 multiply and 96 divide steps; an update makes up to two passes and a
//   delay query up to four passes plus a walk over the flows
// throughput: one word at a time; the next word is taken once this one's result is registered
// reset clears the registers, pause bits and the per-entry valid bits; no clearing pass
module windowed_rate_fair_share_shaper_unit #(
  parameter int FLOWS       = 8,
  parameter int WINDOW_SIZE = 65536
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [wrfs_pkg::ApbAddrW-1:0] paddr,
  input  logic [wrfs_pkg::ApbDataW-1:0] pwdata,
  output logic [wrfs_pkg::ApbDataW-1:0] prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    mode_i,
  input  logic [2:0]                    flow_i,
  input  logic                          direction_i,
  input  logic [wrfs_pkg::DataW-1:0]    transferred_bytes_i,
  input  logic [wrfs_pkg::DataW-1:0]    now_us_i,
  input  logic                          pause_value_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [wrfs_pkg::DataW-1:0]    delay_us_o,
  output logic [wrfs_pkg::DataW-1:0]    current_rate_o,
  output logic                          saturated_o
);
  import wrfs_pkg::*;

  localparam int NumFlows = (FLOWS < MaskW) ? FLOWS : MaskW;
  localparam int Slots    = 2 * NumFlows;
  localparam int FiW      = $clog2(NumFlows);
  localparam int SlotW    = FiW + 1;
  localparam int CntW     = $clog2(NumFlows + 1);
  localparam int QuotaW   = LimitW + 4;

  localparam longint KeepL = WINDOW_SIZE / 3;
  localparam logic [DataW-1:0] Keep       = DataW'(KeepL);
  localparam logic [DataW-1:0] KeepScaled = DataW'(KeepL * 1000000);
  localparam logic [DataW-1:0] WinBytes   = DataW'(WINDOW_SIZE);

  localparam logic [1:0] RegUpload   = 2'd0;
  localparam logic [1:0] RegDownload = 2'd1;
  localparam logic [1:0] RegMember   = 2'd2;

  typedef struct packed {
    logic [DataW-1:0] lc;
    logic [DataW-1:0] ws;
    logic [DataW-1:0] lt;
    logic [DataW-1:0] wb;
    logic [DataW-1:0] wr;
  } ent_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_UPD_WB,
    S_UPD_SUM,
    S_UPD_RATE,
    S_SLIDE_DIV,
    S_DLY_QUOTA,
    S_DLY_RD,
    S_DLY_CHK,
    S_DLY_POOL,
    S_DLY_SHARE,
    S_DLY_CMP,
    S_DLY_QA,
    S_DLY_QB,
    S_WB,
    S_OUT
  } state_e;

  function automatic logic [DataW-1:0] sat48(logic [ProdW-1:0] v);
    return (v[ProdW-1:DataW] != '0) ? '1 : v[DataW-1:0];
  endfunction

  // configuration registers
  logic [LimitW-1:0] upl_q, dnl_q;
  logic [MaskW-1:0]  member_q;
  logic              cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upl_q    <= '0;
      dnl_q    <= '0;
      member_q <= '0;
    end else if (cfg_we) begin
      case (paddr[4:3])
        RegUpload:   upl_q    <= pwdata[LimitW-1:0];
        RegDownload: dnl_q    <= pwdata[LimitW-1:0];
        RegMember:   member_q <= pwdata[MaskW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:3])
      RegUpload:   prdata = {{(ApbDataW-LimitW){1'b0}}, upl_q};
      RegDownload: prdata = {{(ApbDataW-LimitW){1'b0}}, dnl_q};
      RegMember:   prdata = {{(ApbDataW-MaskW){1'b0}}, member_q};
      default:     prdata = '0;
    endcase
  end

  // sequencer state and working registers
  state_e            state_q;
  mode_e             mode_q;
  logic [2:0]        flow_q;
  logic              dir_q;
  logic [DataW-1:0]  bytes_q, now_q;
  logic              pv_q, bad_q;
  logic [DataW-1:0]  e_lc_q, e_ws_q, e_lt_q, e_wb_q, e_wr_q, el_q;
  logic [QuotaW-1:0] quota_q, pool_q;
  logic [CntW-1:0]   cnt_q;
  logic [FiW-1:0]    fi_q;
  logic [ProdW-1:0]  qa_q;
  logic [DataW-1:0]  res_delay_q;
  logic              res_sat_q;
  md_req_t           md_req_q;
  logic [Slots-1:0]  paused_q, valid_q;
  logic              out_valid_q, out_sat_q;
  logic [DataW-1:0]  out_delay_q, out_rate_q;

  logic              md_done;
  logic [ProdW-1:0]  md_quot;

  // meter memory
  ent_t              mem_q [Slots];
  ent_t              rd_ent_q, rd_ent, wr_ent;
  logic              rd_valid_q;
  logic              mem_re, mem_we, in_acc;
  logic [SlotW-1:0]  mem_ra, slot;

  assign in_stall_o = state_q != S_IDLE;
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign slot       = {flow_q[FiW-1:0], dir_q};
  assign mem_we     = state_q == S_WB;
  assign mem_re     = in_acc | (state_q == S_DLY_RD);
  assign mem_ra     = (state_q == S_DLY_RD) ? {fi_q, dir_q}
                                            : {flow_i[FiW-1:0], direction_i};
  assign wr_ent     = '{lc: e_lc_q, ws: e_ws_q, lt: e_lt_q, wb: e_wb_q, wr: e_wr_q};
  assign rd_ent     = rd_valid_q ? rd_ent_q : '0;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[slot] <= wr_ent;
    end
    if (mem_re) begin
      rd_ent_q   <= mem_q[mem_ra];
      rd_valid_q <= valid_q[mem_ra];
    end
  end

  // update step values taken from the entry just read, plus the active-flow count and share check of the delay query
  logic             u_clr;
  ent_t             u_ent;
  logic [DataW-1:0] u_ws, u_el;
  logic [DataW:0]   wb_sum;
  logic [DataW-1:0] wb_new;
  logic [CntW-1:0]  act_cnt;
  logic [DataW-1:0] quota_ext;
  logic             chk_take;

  always_comb begin
    u_clr  = bytes_q < rd_ent.lc;
    u_ent  = u_clr ? '0 : rd_ent;
    u_ws   = (u_ent.ws == '0) ? now_q : u_ent.ws;
    u_el   = (now_q >= u_ws) ? now_q - u_ws : '0;
    wb_sum = {1'b0, e_wb_q} + {1'b0, bytes_q - e_lc_q};
    wb_new = wb_sum[DataW] ? '1 : wb_sum[DataW-1:0];
    act_cnt = '0;
    for (int i = 0; i < NumFlows; i++) begin
      act_cnt = act_cnt + CntW'(member_q[i] & ~paused_q[{FiW'(i), dir_q}]);
    end
    quota_ext = {{(DataW-QuotaW){1'b0}}, quota_q};
    chk_take  = member_q[fi_q] & ~paused_q[{fi_q, dir_q}] & (rd_ent.wr < quota_ext);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= MODE_UPDATE;
      flow_q      <= '0;
      dir_q       <= 1'b0;
      bytes_q     <= '0;
      now_q       <= '0;
      pv_q        <= 1'b0;
      bad_q       <= 1'b0;
      e_lc_q      <= '0;
      e_ws_q      <= '0;
      e_lt_q      <= '0;
      e_wb_q      <= '0;
      e_wr_q      <= '0;
      el_q        <= '0;
      quota_q     <= '0;
      pool_q      <= '0;
      cnt_q       <= '0;
      fi_q        <= '0;
      qa_q        <= '0;
      res_delay_q <= '0;
      res_sat_q   <= 1'b0;
      md_req_q    <= '0;
      paused_q    <= '0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
      out_sat_q   <= 1'b0;
      out_delay_q <= '0;
      out_rate_q  <= '0;
    end else begin
      md_req_q.start <= 1'b0;
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            mode_q      <= mode_e'(mode_i);
            flow_q      <= flow_i;
            dir_q       <= direction_i;
            bytes_q     <= transferred_bytes_i;
            now_q       <= now_us_i;
            pv_q        <= pause_value_i;
            bad_q       <= 32'(flow_i) >= FLOWS;
            res_delay_q <= '0;
            res_sat_q   <= 1'b0;
            state_q     <= S_READ;
          end
        end
        S_READ: begin
          e_lc_q <= rd_ent.lc;
          e_ws_q <= rd_ent.ws;
          e_lt_q <= rd_ent.lt;
          e_wb_q <= rd_ent.wb;
          e_wr_q <= rd_ent.wr;
          if (bad_q) begin
            e_wr_q  <= '0;
            state_q <= S_OUT;
          end else begin
            case (mode_q)
              MODE_UPDATE: begin
                e_lc_q <= u_ent.lc;
                e_wb_q <= u_ent.wb;
                e_wr_q <= u_ent.wr;
                e_lt_q <= now_q;
                if (now_q == '0) begin
                  e_ws_q  <= u_ent.ws;
                  state_q <= S_WB;
                end else begin
                  e_ws_q <= u_ws;
                  el_q   <= u_el;
                  if (u_ent.wb == '0 && u_ent.wr != '0) begin
                    // rebuild the byte count from the rate over the window so far
                    md_req_q <= '{start: 1'b1, a: u_el, b: u_ent.wr, d: RateScale};
                    state_q  <= S_UPD_WB;
                  end else begin
                    state_q <= S_UPD_SUM;
                  end
                end
              end
              MODE_SLIDE: begin
                if (rd_ent.wb >= WinBytes && rd_ent.wr != '0) begin
                  md_req_q <= '{start: 1'b1, a: KeepScaled, b: DataW'(1), d: rd_ent.wr};
                  state_q  <= S_SLIDE_DIV;
                end else begin
                  state_q <= S_OUT;
                end
              end
              MODE_DELAY: begin
                if (!member_q[flow_q] || paused_q[slot] || act_cnt == '0) begin
                  state_q <= S_OUT;
                end else begin
                  cnt_q    <= act_cnt;
                  md_req_q <= '{start: 1'b1,
                                a: DataW'(dir_q ? dnl_q : upl_q),
                                b: DataW'(1),
                                d: DataW'(act_cnt)};
                  state_q  <= S_DLY_QUOTA;
                end
              end
              MODE_PAUSE: begin
                paused_q[slot] <= pv_q;
                state_q        <= S_OUT;
              end
              default: state_q <= S_OUT;
            endcase
          end
        end
        S_UPD_WB: begin
          if (md_done) begin
            e_wb_q  <= sat48(md_quot);
            state_q <= S_UPD_SUM;
          end
        end
        S_UPD_SUM: begin
          e_wb_q <= wb_new;
          e_lc_q <= bytes_q;
          if (el_q == '0) begin
            state_q <= S_WB;
          end else begin
            md_req_q <= '{start: 1'b1, a: wb_new, b: RateScale, d: el_q};
            state_q  <= S_UPD_RATE;
          end
        end
        S_UPD_RATE: begin
          if (md_done) begin
            e_wr_q  <= sat48(md_quot);
            state_q <= S_WB;
          end
        end
        S_SLIDE_DIV: begin
          if (md_done) begin
            e_ws_q  <= ({{DataW{1'b0}}, e_lt_q} >= md_quot) ?
                       e_lt_q - md_quot[DataW-1:0] : '0;
            e_wb_q  <= Keep;
            state_q <= S_WB;
          end
        end
        S_DLY_QUOTA: begin
          if (md_done) begin
            quota_q <= md_quot[QuotaW-1:0];
            pool_q  <= '0;
            fi_q    <= '0;
            if (e_wr_q <= md_quot[DataW-1:0]) begin
              state_q <= S_OUT;
            end else begin
              state_q <= S_DLY_RD;
            end
          end
        end
        S_DLY_RD: begin
          state_q <= S_DLY_CHK;
        end
        S_DLY_CHK: begin
          // slower flows hand their unused share to the pool
          if (chk_take) begin
            pool_q <= pool_q + (quota_q - rd_ent.wr[QuotaW-1:0]);
            cnt_q  <= cnt_q - 1'b1;
          end
          if (fi_q == FiW'(NumFlows - 1)) begin
            state_q <= S_DLY_POOL;
          end else begin
            fi_q    <= fi_q + 1'b1;
            state_q <= S_DLY_RD;
          end
        end
        S_DLY_POOL: begin
          if (cnt_q != '0) begin
            md_req_q <= '{start: 1'b1, a: DataW'(pool_q), b: DataW'(1), d: DataW'(cnt_q)};
            state_q  <= S_DLY_SHARE;
          end else begin
            state_q <= S_DLY_CMP;
          end
        end
        S_DLY_SHARE: begin
          if (md_done) begin
            quota_q <= quota_q + md_quot[QuotaW-1:0];
            state_q <= S_DLY_CMP;
          end
        end
        S_DLY_CMP: begin
          if (e_wr_q <= quota_ext) begin
            state_q <= S_OUT;
          end else if (quota_q == '0) begin
            res_delay_q <= '1;
            res_sat_q   <= 1'b1;
            state_q     <= S_OUT;
          end else begin
            md_req_q <= '{start: 1'b1, a: e_wb_q, b: RateScale, d: quota_ext};
            state_q  <= S_DLY_QA;
          end
        end
        S_DLY_QA: begin
          if (md_done) begin
            qa_q     <= md_quot;
            md_req_q <= '{start: 1'b1, a: e_wb_q, b: RateScale, d: e_wr_q};
            state_q  <= S_DLY_QB;
          end
        end
        S_DLY_QB: begin
          if (md_done) begin
            res_delay_q <= sat48(qa_q - md_quot);
            state_q     <= S_OUT;
          end
        end
        S_WB: begin
          valid_q[slot] <= 1'b1;
          state_q       <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            out_delay_q <= res_delay_q;
            out_rate_q  <= e_wr_q;
            out_sat_q   <= res_sat_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  wrfs_muldiv u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (md_req_q),
    .done_o (md_done),
    .quot_o (md_quot)
  );

  assign out_valid_o    = out_valid_q;
  assign delay_us_o     = out_delay_q;
  assign current_rate_o = out_rate_q;
  assign saturated_o    = out_sat_q;

  a_md_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    md_req_q.start |-> md_req_q.d != '0)
    else $error("mul-div request with zero divisor");

  a_share_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DLY_POOL |-> cnt_q != '0)
    else $error("addressed flow dropped from the fast-flow count");

  a_delay_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DLY_QB && md_done) |-> qa_q >= md_quot)
    else $error("time at quota below time at current rate");

endmodule

@@ tb/windowed_rate_fair_share_shaper_unit_tb.sv @@
// testbench of the fair-share shaper: bit-exact meter predictor, random traffic, backpressure
module windowed_rate_fair_share_shaper_unit_tb;
  import wrfs_pkg::*;

  localparam logic [47:0] Max48 = 48'hFFFF_FFFF_FFFF;
  localparam logic [39:0] Max40 = 40'hFF_FFFF_FFFF;
  localparam int Slots = 16;
  localparam int KeepBytes = 65536 / 3;
  localparam int CycleLimit = 4000000;

  typedef enum logic [4:0] {
    REG_UPLOAD   = 5'd0,
    REG_DOWNLOAD = 5'd8,
    REG_MASK     = 5'd16
  } reg_addr_e;

  typedef struct packed {
    logic [47:0] delay;
    logic [47:0] rate;
    logic        sat;
  } shaper_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ApbAddrW-1:0] paddr = '0;
  logic [ApbDataW-1:0] pwdata = '0;
  logic [ApbDataW-1:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] mode_i = '0;
  logic [2:0] flow_i = '0;
  logic direction_i = 1'b0;
  logic [47:0] transferred_bytes_i = '0;
  logic [47:0] now_us_i = '0;
  logic pause_value_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [47:0] delay_us_o, current_rate_o;
  logic saturated_o;

  windowed_rate_fair_share_shaper_unit DUT (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // predictor state
  logic [39:0] up_limit, down_limit;
  logic [7:0]  members;
  logic [47:0] m_count[Slots], m_wstart[Slots], m_ltime[Slots], m_wbytes[Slots], m_wrate[Slots];
  logic        m_paused[Slots];

  shaper_word_t expected_words[$];
  int errors = 0;
  int cycles = 0;
  bit quiet = 0;
  bit long_hold_req = 0;
  bit gaps_on = 1;

  // stimulus trackers for well-formed meter sequences
  logic [47:0] gen_bytes[Slots], gen_time[Slots];

  function automatic logic [47:0] clip48(logic [127:0] v);
    return (v > {80'b0, Max48}) ? Max48 : v[47:0];
  endfunction

  function automatic logic [47:0] scaled_quot(logic [63:0] a, logic [63:0] b, logic [63:0] d);
    logic [127:0] p;
    p = ({64'b0, a} * {64'b0, b}) / {64'b0, d};
    return clip48(p);
  endfunction

  task automatic meter_update(int s, logic [47:0] bytes, logic [47:0] now);
    logic [63:0] elapsed, sum;
    if (bytes < m_count[s]) begin
      m_count[s] = 0; m_wstart[s] = 0; m_ltime[s] = 0; m_wbytes[s] = 0; m_wrate[s] = 0;
    end
    m_ltime[s] = now;
    if (now == 0) return;
    if (m_wstart[s] == 0) m_wstart[s] = now;
    elapsed = (now >= m_wstart[s]) ? 64'(now - m_wstart[s]) : 64'd0;
    if (m_wbytes[s] == 0 && m_wrate[s] > 0)
      m_wbytes[s] = scaled_quot(elapsed, 64'(m_wrate[s]), 64'd1000000);
    sum = 64'(m_wbytes[s]) + 64'(bytes - m_count[s]);
    m_wbytes[s] = (sum > 64'(Max48)) ? Max48 : sum[47:0];
    m_count[s] = bytes;
    if (elapsed == 0) return;
    m_wrate[s] = scaled_quot(64'(m_wbytes[s]), 64'd1000000, elapsed);
  endtask

  task automatic meter_slide(int s);
    logic [63:0] back;
    if (m_wbytes[s] >= 48'd65536 && m_wrate[s] > 0) begin
      back = (64'(KeepBytes) * 64'd1000000) / 64'(m_wrate[s]);
      m_wstart[s] = (64'(m_ltime[s]) >= back) ? 48'(64'(m_ltime[s]) - back) : 48'd0;
      m_wbytes[s] = 48'(KeepBytes);
    end
  endtask

  task automatic fair_delay(int f, int dir, output logic [47:0] delay, output logic sat);
    int s, t, active;
    logic [63:0] quota, pool, rate;
    logic [127:0] qa, qb;
    s = f * 2 + dir;
    delay = 0; sat = 0; active = 0; pool = 0;
    rate = 64'(m_wrate[s]);
    if (!members[f] || m_paused[s]) return;
    for (int i = 0; i < 8; i++)
      if (members[i] && !m_paused[i*2+dir]) active++;
    if (active == 0) return;
    quota = 64'(dir ? down_limit : up_limit) / 64'(active);
    if (rate <= quota) return;
    for (int i = 0; i < 8; i++) begin
      t = i * 2 + dir;
      if (members[i] && !m_paused[t] && 64'(m_wrate[t]) < quota) begin
        pool += quota - 64'(m_wrate[t]);
        active--;
      end
    end
    if (active > 0) quota += pool / 64'(active);
    if (rate <= quota) return;
    if (quota == 0) begin
      sat = 1; delay = Max48; return;
    end
    qa = ({80'b0, m_wbytes[s]} * 128'd1000000) / {64'b0, quota};
    qb = ({80'b0, m_wbytes[s]} * 128'd1000000) / {64'b0, rate};
    delay = clip48(qa - qb);
  endtask

  task automatic predict_word(mode_e md, int f, int dir, logic [47:0] bytes, logic [47:0] now,
                              logic pv);
    shaper_word_t w;
    int s;
    s = f * 2 + dir;
    w = '0;
    case (md)
      MODE_UPDATE: meter_update(s, bytes, now);
      MODE_SLIDE:  meter_slide(s);
      MODE_DELAY:  fair_delay(f, dir, w.delay, w.sat);
      default:     m_paused[s] = pv;
    endcase
    w.rate = m_wrate[s];
    expected_words.push_back(w);
  endtask

  // sends one word and waits until it is taken
  task automatic send_word(mode_e md, int f, int dir, logic [47:0] bytes, logic [47:0] now,
                           logic pv);
    @(negedge clk_i);
    in_valid_i = 1'b1;
    mode_i = md; flow_i = 3'(f); direction_i = dir[0];
    transferred_bytes_i = bytes; now_us_i = now; pause_value_i = pv;
    forever begin
      @(posedge clk_i);
      if (!in_stall_o) break;
    end
    predict_word(md, f, dir, bytes, now, pv);
    if (gaps_on && !quiet && $urandom_range(0, 3) == 0) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat ($urandom_range(0, 10)) @(negedge clk_i);
    end
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic apb_write(reg_addr_e a, logic [63:0] v);
    @(negedge clk_i);
    in_valid_i = 1'b0;
    psel = 1'b1; pwrite = 1'b1; penable = 1'b0; paddr = a; pwdata = v;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    case (a)
      REG_UPLOAD:   up_limit = v[39:0];
      REG_DOWNLOAD: down_limit = v[39:0];
      default:      members = v[7:0];
    endcase
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  task automatic set_config(logic [63:0] up, logic [63:0] down, logic [63:0] mask);
    wait_idle();
    apb_write(REG_UPLOAD, up);
    apb_write(REG_DOWNLOAD, down);
    apb_write(REG_MASK, mask);
  endtask

  // one random word: mostly well-formed meter traffic, some noise
  task automatic random_word();
    int f, dir, s, pick;
    logic [47:0] b, t;
    f = $urandom_range(0, 7); dir = $urandom_range(0, 1); s = f * 2 + dir;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      b = 48'({$urandom, $urandom}); t = 48'({$urandom, $urandom});
      send_word(mode_e'($urandom_range(0, 3)), f, dir, b, t, 1'($urandom_range(0, 1)));
    end else if (pick < 50) begin
      if ($urandom_range(0, 40) == 0) gen_bytes[s] = 48'($urandom_range(0, 1000));
      else gen_bytes[s] += 48'($urandom_range(0, 60000));
      if ($urandom_range(0, 40) == 0) gen_time[s] -= 48'($urandom_range(0, 500));
      else gen_time[s] += 48'($urandom_range(1, 30000));
      send_word(MODE_UPDATE, f, dir, gen_bytes[s], gen_time[s], 1'b0);
    end else if (pick < 62) begin
      send_word(MODE_SLIDE, f, dir, '0, '0, 1'b0);
    end else if (pick < 90) begin
      send_word(MODE_DELAY, f, dir, '0, '0, 1'b0);
    end else begin
      send_word(MODE_PAUSE, f, dir, '0, '0, $urandom_range(0, 3) == 0);
    end
  endtask

  task automatic test_directed();
    set_config(64'd1000, 64'd0, 64'hFF);
    send_word(MODE_UPDATE, 0, 0, 48'd0, 48'd0, 1'b0);          // time zero
    send_word(MODE_UPDATE, 0, 0, 48'd1000, 48'd100, 1'b0);     // window starts
    send_word(MODE_UPDATE, 0, 0, 48'd50000, 48'd1100, 1'b0);
    send_word(MODE_UPDATE, 0, 0, 48'd200000, 48'd2000, 1'b0);
    send_word(MODE_SLIDE, 0, 0, '0, '0, 1'b0);
    send_word(MODE_DELAY, 0, 0, '0, '0, 1'b0);
    send_word(MODE_UPDATE, 0, 0, 48'd10, 48'd3000, 1'b0);      // count falls back
    send_word(MODE_UPDATE, 0, 0, 48'd500, 48'd2500, 1'b0);
    send_word(MODE_UPDATE, 0, 0, 48'd900, 48'd2000, 1'b0);     // time backwards
    send_word(MODE_UPDATE, 1, 1, 48'd5000, 48'd10, 1'b0);
    send_word(MODE_UPDATE, 1, 1, Max48, 48'd11, 1'b0);         // saturating window
    send_word(MODE_SLIDE, 1, 1, '0, '0, 1'b0);
    send_word(MODE_DELAY, 1, 1, '0, '0, 1'b0);                 // zero quota
    send_word(MODE_PAUSE, 1, 1, '0, '0, 1'b1);
    send_word(MODE_DELAY, 1, 1, '0, '0, 1'b0);                 // paused flow
    send_word(MODE_PAUSE, 1, 1, '0, '0, 1'b0);
    send_word(MODE_UPDATE, 7, 0, 48'd1, Max48, 1'b0);
    send_word(MODE_UPDATE, 7, 0, Max48, Max48, 1'b0);
    send_word(MODE_SLIDE, 7, 0, '0, '0, 1'b0);
    set_config(64'(Max40), 64'(Max40), 64'h00);
    send_word(MODE_DELAY, 0, 0, '0, '0, 1'b0);                 // not a member
    set_config(64'd0, 64'd1, 64'h01);
    send_word(MODE_DELAY, 0, 0, '0, '0, 1'b0);
    send_word(MODE_DELAY, 1, 1, '0, '0, 1'b0);
  endtask

  task automatic test_random_traffic(int n);
    for (int k = 0; k < n; k++) begin
      if (k % 120 == 0) begin
        case ($urandom_range(0, 3))
          0: set_config(64'(Max40), 64'(Max40), 64'hFF);
          1: set_config(64'd0, 64'd0, {$urandom, $urandom});
          default: set_config($urandom_range(1000, 3000000), $urandom_range(1000, 3000000),
                              $urandom_range(0, 255));
        endcase
      end
      random_word();
    end
  endtask

  task automatic test_backpressure();
    long_hold_req = 1;
    gaps_on = 0;
    for (int k = 0; k < 20; k++) random_word();
    gaps_on = 1;
  endtask

  // receiver stall
  initial begin
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        out_stall_i = 1'b1;
        repeat (3000) @(negedge clk_i);
        out_stall_i = 1'b0;
        long_hold_req = 0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall_i = 1'b1;
        repeat ($urandom_range(1, 11) - 1) @(negedge clk_i);
      end else begin
        out_stall_i = 1'b0;
        if (!quiet) repeat ($urandom_range(0, 15)) @(negedge clk_i);
      end
    end
  end

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_words.size() == 0) begin
        $display("%0t unexpected word: delay %h rate %h sat %b",
                 $time, delay_us_o, current_rate_o, saturated_o);
        errors++;
      end else begin
        shaper_word_t w;
        w = expected_words.pop_front();
        if (delay_us_o !== w.delay) begin
          $display("%0t delay_us expected %h actual %h", $time, w.delay, delay_us_o);
          errors++;
        end
        if (current_rate_o !== w.rate) begin
          $display("%0t current_rate expected %h actual %h", $time, w.rate, current_rate_o);
          errors++;
        end
        if (saturated_o !== w.sat) begin
          $display("%0t saturated expected %b actual %b", $time, w.sat, saturated_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    up_limit = 0; down_limit = 0; members = 0;
    for (int i = 0; i < Slots; i++) begin
      m_count[i] = 0; m_wstart[i] = 0; m_ltime[i] = 0; m_wbytes[i] = 0; m_wrate[i] = 0;
      m_paused[i] = 0; gen_bytes[i] = 0; gen_time[i] = 48'd1000;
    end
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_random_traffic(300);
    test_backpressure();
    test_random_traffic(250);
    quiet = 1;
    test_random_traffic(80);
    wait_idle();
    repeat (700) @(posedge clk_i);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/wrfs_pkg.sv
src/wrfs_muldiv.sv
src/windowed_rate_fair_share_shaper_unit.sv
tb/windowed_rate_fair_share_shaper_unit_tb.sv
